@@ sv/gaps_pkg.sv @@
// shared types, codes and direction helpers for the grid path search core
package gaps_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PATH = 2'd1,
    ST_BAD_END = 2'd2,
    ST_BEYOND  = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_START_X     = 3'd2;
  localparam logic [2:0] CFG_START_Y     = 3'd3;
  localparam logic [2:0] CFG_GOAL_X      = 3'd4;
  localparam logic [2:0] CFG_GOAL_Y      = 3'd5;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SWEEP_OBS,
    DP_SWEEP_NODE,
    DP_OBS_WRITE,
    DP_RD_START,
    DP_RD_GOAL,
    DP_INIT,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_CLOSE,
    DP_NB_READ,
    DP_NB_EVAL,
    DP_TR_READ,
    DP_TR_STEP,
    DP_PATH_READ
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    take;
    logic    load_search;
    logic    load_read;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic ends_bad;
    logic goal_open;
    logic scan_last;
    logic found;
    logic nb_last;
    logic tr_done;
  } dp_sts_t;

  // neighbor direction k: 0..2 row above, 3 left, 4 right, 5..7 row below
  function automatic logic dir_xm(input logic [2:0] k);
    return (k inside {3'd0, 3'd3, 3'd5});
  endfunction

  function automatic logic dir_xp(input logic [2:0] k);
    return (k inside {3'd2, 3'd4, 3'd7});
  endfunction

  function automatic logic dir_ym(input logic [2:0] k);
    return (k inside {3'd0, 3'd1, 3'd2});
  endfunction

  function automatic logic dir_yp(input logic [2:0] k);
    return (k inside {3'd5, 3'd6, 3'd7});
  endfunction

endpackage

@@ sv/gaps_dp.sv @@
// datapath of the grid path search: maps, node store, scan, expansion, trace, result
module gaps_dp #(
  parameter int MAX_SIDE  = 64,
  parameter int COST_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gaps_pkg::cmd_t    cmd,
  output gaps_pkg::dp_sts_t sts,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic [5:0]        cell_x,
  input  logic [5:0]        cell_y,
  input  logic              blocked,
  input  logic [11:0]       path_index,
  output logic [1:0]        status,
  output logic [15:0]       path_cost,
  output logic [12:0]       path_length,
  output logic [5:0]        out_x,
  output logic [5:0]        out_y
);

  localparam int SB    = $clog2(MAX_SIDE);
  localparam int CB    = 2 * SB;
  localparam int NCELL = 1 << CB;
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int PB    = $clog2(CELLS);
  localparam int NB    = $clog2(CELLS + 1);
  localparam int WB    = $clog2(MAX_SIDE + 1);
  localparam int HB    = $clog2(20 * MAX_SIDE);
  localparam int FB    = ((COST_BITS > HB) ? COST_BITS : HB) + 1;
  localparam int NW    = 2 + COST_BITS + 3;

  localparam logic [1:0] NS_NONE   = 2'd0;
  localparam logic [1:0] NS_OPEN   = 2'd1;
  localparam logic [1:0] NS_CLOSED = 2'd2;

  // configuration
  logic [6:0] grid_width, grid_height;
  logic [5:0] start_x, start_y, goal_x, goal_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      start_x     <= '0;
      start_y     <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gaps_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        gaps_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        gaps_pkg::CFG_START_X:     start_x     <= cfg_data[5:0];
        gaps_pkg::CFG_START_Y:     start_y     <= cfg_data[5:0];
        gaps_pkg::CFG_GOAL_X:      goal_x      <= cfg_data[5:0];
        gaps_pkg::CFG_GOAL_Y:      goal_y      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0] w_sat, h_sat;
  logic [SB-1:0] sx, sy, gx, gy;
  logic [CB-1:0] s_idx, g_idx;
  logic          range_bad;

  assign w_sat = (32'(grid_width) > MAX_SIDE) ? WB'(MAX_SIDE) : WB'(grid_width);
  assign h_sat = (32'(grid_height) > MAX_SIDE) ? WB'(MAX_SIDE) : WB'(grid_height);
  assign sx = SB'(start_x);
  assign sy = SB'(start_y);
  assign gx = SB'(goal_x);
  assign gy = SB'(goal_y);
  assign s_idx = {sy, sx};
  assign g_idx = {gy, gx};
  assign range_bad = (32'(start_x) >= 32'(w_sat)) || (32'(start_y) >= 32'(h_sat)) ||
                     (32'(goal_x) >= 32'(w_sat)) || (32'(goal_y) >= 32'(h_sat));

  // captured item
  logic [5:0]  cap_x, cap_y;
  logic        cap_blk;
  logic [11:0] cap_pi;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cap_x   <= cell_x;
      cap_y   <= cell_y;
      cap_blk <= blocked;
      cap_pi  <= path_index;
    end
  end

  // control registers
  logic [CB-1:0]        sweep;
  logic [SB-1:0]        scan_x, scan_y;
  logic                 pend, found, goal_open, obs_s, nb_ok, beyond;
  logic [CB-1:0]        pidx, best, n_reg, c;
  logic [HB-1:0]        h_reg;
  logic [FB-1:0]        best_f;
  logic [COST_BITS-1:0] best_g, kept;
  logic [2:0]           best_p, k;
  logic [NB-1:0]        count;

  // node store read data
  logic [NW-1:0]        node_rd;
  logic [1:0]           nd_st;
  logic [COST_BITS-1:0] nd_g;
  logic [2:0]           nd_p;
  logic                 obs_rd;

  assign nd_st = node_rd[NW-1 -: 2];
  assign nd_g  = node_rd[3 +: COST_BITS];
  assign nd_p  = node_rd[2:0];

  // scan heuristic
  logic [SB-1:0] adx, ady;
  logic [SB:0]   l1;
  logic [HB-1:0] h_now;
  logic [FB-1:0] f_now;
  logic          scan_xl, scan_yl;

  assign adx = (scan_x > gx) ? scan_x - gx : gx - scan_x;
  assign ady = (scan_y > gy) ? scan_y - gy : gy - scan_y;
  assign l1 = {1'b0, adx} + {1'b0, ady};
  assign h_now = (HB'(l1) << 3) + (HB'(l1) << 1);
  assign f_now = FB'(nd_g) + FB'(h_reg);
  assign scan_xl = (32'(scan_x) + 1) == 32'(w_sat);
  assign scan_yl = (32'(scan_y) + 1) == 32'(h_sat);

  // neighbor of the expanded cell
  logic [SB-1:0]        bx, by, nx, ny;
  logic [CB-1:0]        n_idx;
  logic                 n_in;
  logic [COST_BITS:0]   g_sum;
  logic [COST_BITS-1:0] ng;
  logic                 diag, upd;

  assign bx = best[SB-1:0];
  assign by = best[CB-1:SB];
  assign nx = gaps_pkg::dir_xm(k) ? bx - 1'b1 : (gaps_pkg::dir_xp(k) ? bx + 1'b1 : bx);
  assign ny = gaps_pkg::dir_ym(k) ? by - 1'b1 : (gaps_pkg::dir_yp(k) ? by + 1'b1 : by);
  assign n_idx = {ny, nx};
  assign n_in = !(gaps_pkg::dir_xm(k) && bx == '0) &&
                !(gaps_pkg::dir_xp(k) && (32'(bx) + 1) >= 32'(w_sat)) &&
                !(gaps_pkg::dir_ym(k) && by == '0) &&
                !(gaps_pkg::dir_yp(k) && (32'(by) + 1) >= 32'(h_sat));
  assign diag = (gaps_pkg::dir_xm(k) || gaps_pkg::dir_xp(k)) &&
                (gaps_pkg::dir_ym(k) || gaps_pkg::dir_yp(k));
  assign g_sum = {1'b0, best_g} + (diag ? (COST_BITS + 1)'(14) : (COST_BITS + 1)'(10));
  assign ng = g_sum[COST_BITS] ? '1 : g_sum[COST_BITS-1:0];
  assign upd = nb_ok && !obs_rd && (nd_st != NS_CLOSED) &&
               ((nd_st != NS_OPEN) || (ng < nd_g));

  // trace step toward the parent
  logic [SB-1:0] tx, ty, px, py;
  logic          p_out;

  assign tx = c[SB-1:0];
  assign ty = c[CB-1:SB];
  assign px = gaps_pkg::dir_xm(nd_p) ? tx - 1'b1 : (gaps_pkg::dir_xp(nd_p) ? tx + 1'b1 : tx);
  assign py = gaps_pkg::dir_ym(nd_p) ? ty - 1'b1 : (gaps_pkg::dir_yp(nd_p) ? ty + 1'b1 : ty);
  assign p_out = (gaps_pkg::dir_xm(nd_p) && tx == '0) ||
                 (gaps_pkg::dir_xp(nd_p) && 32'(tx) == MAX_SIDE - 1) ||
                 (gaps_pkg::dir_ym(nd_p) && ty == '0) ||
                 (gaps_pkg::dir_yp(nd_p) && 32'(ty) == MAX_SIDE - 1);

  // obstacle map
  logic             obs_mem [NCELL];
  logic [CB-1:0]    obs_addr;
  logic             obs_we, obs_wd;

  always_comb begin
    obs_addr = sweep;
    obs_we   = 1'b0;
    obs_wd   = 1'b0;
    case (cmd.op)
      gaps_pkg::DP_SWEEP_OBS: obs_we = 1'b1;
      gaps_pkg::DP_OBS_WRITE: begin
        obs_addr = {SB'(cap_y), SB'(cap_x)};
        obs_we   = (32'(cap_x) < MAX_SIDE) && (32'(cap_y) < MAX_SIDE);
        obs_wd   = cap_blk;
      end
      gaps_pkg::DP_RD_START: obs_addr = s_idx;
      gaps_pkg::DP_RD_GOAL:  obs_addr = g_idx;
      gaps_pkg::DP_NB_READ:  obs_addr = n_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_addr] <= obs_wd;
    end
    obs_rd <= obs_mem[obs_addr];
  end

  // node store: state, g and parent direction per cell
  logic [NW-1:0] node_mem [NCELL];
  logic [CB-1:0] node_addr;
  logic          node_we;
  logic [NW-1:0] node_wd;

  always_comb begin
    node_addr = sweep;
    node_we   = 1'b0;
    node_wd   = '0;
    case (cmd.op)
      gaps_pkg::DP_SWEEP_OBS, gaps_pkg::DP_SWEEP_NODE: node_we = 1'b1;
      gaps_pkg::DP_INIT: begin
        node_addr = s_idx;
        node_we   = 1'b1;
        node_wd   = {NS_OPEN, {COST_BITS{1'b0}}, 3'd0};
      end
      gaps_pkg::DP_SCAN_STEP: node_addr = {scan_y, scan_x};
      gaps_pkg::DP_CLOSE: begin
        node_addr = best;
        node_we   = 1'b1;
        node_wd   = {NS_CLOSED, best_g, best_p};
      end
      gaps_pkg::DP_NB_READ: node_addr = n_idx;
      gaps_pkg::DP_NB_EVAL: begin
        node_addr = n_reg;
        node_we   = upd;
        node_wd   = {NS_OPEN, ng, 3'd7 - k};
      end
      gaps_pkg::DP_TR_READ: node_addr = c;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_addr] <= node_wd;
    end
    node_rd <= node_mem[node_addr];
  end

  // path list
  logic [CB-1:0] path_mem [CELLS];
  logic [CB-1:0] path_rd;

  always_ff @(posedge clk) begin
    if (cmd.op == gaps_pkg::DP_TR_STEP) begin
      path_mem[count[PB-1:0]] <= c;
    end
    if (cmd.op == gaps_pkg::DP_PATH_READ) begin
      path_rd <= path_mem[PB'(cap_pi)];
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      goal_open <= 1'b0;
      count     <= '0;
      kept      <= '0;
      k         <= '0;
    end else begin
      pend <= 1'b0;
      if (pend && nd_st == NS_OPEN && (!found || f_now < best_f)) begin
        found  <= 1'b1;
        best_f <= f_now;
        best   <= pidx;
        best_g <= nd_g;
        best_p <= nd_p;
      end
      case (cmd.op)
        gaps_pkg::DP_SWEEP_OBS, gaps_pkg::DP_SWEEP_NODE: sweep <= sweep + 1'b1;
        gaps_pkg::DP_RD_START: begin
          count <= '0;
          kept  <= '0;
        end
        gaps_pkg::DP_RD_GOAL: obs_s <= obs_rd;
        gaps_pkg::DP_INIT: begin
          goal_open <= (s_idx == g_idx);
          c         <= g_idx;
        end
        gaps_pkg::DP_SCAN_START: begin
          scan_x <= '0;
          scan_y <= '0;
          found  <= 1'b0;
        end
        gaps_pkg::DP_SCAN_STEP: begin
          pend  <= 1'b1;
          pidx  <= {scan_y, scan_x};
          h_reg <= h_now;
          if (scan_xl) begin
            scan_x <= '0;
            scan_y <= scan_y + 1'b1;
          end else begin
            scan_x <= scan_x + 1'b1;
          end
        end
        gaps_pkg::DP_CLOSE: k <= '0;
        gaps_pkg::DP_NB_READ: begin
          n_reg <= n_idx;
          nb_ok <= n_in;
        end
        gaps_pkg::DP_NB_EVAL: begin
          k <= k + 1'b1;
          if (upd && n_reg == g_idx) begin
            goal_open <= 1'b1;
          end
        end
        gaps_pkg::DP_TR_STEP: begin
          count <= count + 1'b1;
          if (count == '0) begin
            kept <= nd_g;
          end
          c <= {py, px};
        end
        gaps_pkg::DP_PATH_READ: beyond <= !(32'(cap_pi) < 32'(count));
        default: ;
      endcase
    end
  end

  assign sts.sweep_last = &sweep;
  assign sts.ends_bad   = range_bad || obs_s || obs_rd;
  assign sts.goal_open  = goal_open;
  assign sts.scan_last  = scan_xl && scan_yl;
  assign sts.found      = found;
  assign sts.nb_last    = (k == 3'd7);
  assign sts.tr_done    = (c == s_idx) || ((32'(count) + 1) == CELLS) || p_out;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      status      <= cmd.res_status;
      path_cost   <= 16'(kept);
      path_length <= 13'(count);
      out_x       <= '0;
      out_y       <= '0;
    end else if (cmd.load_read) begin
      status      <= beyond ? gaps_pkg::ST_BEYOND : gaps_pkg::ST_OK;
      path_cost   <= 16'(kept);
      path_length <= 13'(count);
      out_x       <= beyond ? 6'd0 : 6'(path_rd[SB-1:0]);
      out_y       <= beyond ? 6'd0 : 6'(path_rd[CB-1:SB]);
    end
  end

endmodule

@@ sv/gaps_ctrl.sv @@
// controller state machine of the grid path search
module gaps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        op,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output gaps_pkg::cmd_t    cmd,
  input  gaps_pkg::dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_RST_CLR,
    S_IDLE,
    S_OBS_WR,
    S_RD_S,
    S_RD_G,
    S_CHK,
    S_CLR,
    S_INIT,
    S_LOOP,
    S_SCAN0,
    S_SCAN,
    S_DRAIN,
    S_PICK,
    S_CLOSE,
    S_NB_RD,
    S_NB_EV,
    S_TR_RD,
    S_TR_ST,
    S_RES,
    S_PR_RD,
    S_PR_RES
  } state_t;

  state_t            state;
  gaps_pkg::dp_op_t  cur_op;
  gaps_pkg::status_t res_status;
  logic              stall;
  logic              take, out_free, load_search, load_read;

  assign take        = in_valid && !stall;
  assign out_free    = !out_valid || !out_stall;
  assign load_search = (state == S_RES) && out_free;
  assign load_read   = (state == S_PR_RES) && out_free;
  assign in_stall    = stall;

  assign cmd.op          = cur_op;
  assign cmd.take        = take;
  assign cmd.load_search = load_search;
  assign cmd.load_read   = load_read;
  assign cmd.res_status  = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RST_CLR;
      cur_op     <= gaps_pkg::DP_SWEEP_OBS;
      stall      <= 1'b1;
      out_valid  <= 1'b0;
      res_status <= gaps_pkg::ST_OK;
    end else begin
      if (load_search || load_read) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_RST_CLR: begin
          if (sts.sweep_last) begin
            state  <= S_IDLE;
            cur_op <= gaps_pkg::DP_NOP;
            stall  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (take) begin
            case (op)
              gaps_pkg::OP_WRITE: begin
                state  <= S_OBS_WR;
                cur_op <= gaps_pkg::DP_OBS_WRITE;
                stall  <= 1'b1;
              end
              gaps_pkg::OP_SEARCH: begin
                state  <= S_RD_S;
                cur_op <= gaps_pkg::DP_RD_START;
                stall  <= 1'b1;
              end
              gaps_pkg::OP_READ: begin
                state  <= S_PR_RD;
                cur_op <= gaps_pkg::DP_PATH_READ;
                stall  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_OBS_WR: begin
          state  <= S_IDLE;
          cur_op <= gaps_pkg::DP_NOP;
          stall  <= 1'b0;
        end
        S_RD_S: begin
          state  <= S_RD_G;
          cur_op <= gaps_pkg::DP_RD_GOAL;
        end
        S_RD_G: begin
          state  <= S_CHK;
          cur_op <= gaps_pkg::DP_NOP;
        end
        S_CHK: begin
          if (sts.ends_bad) begin
            state      <= S_RES;
            cur_op     <= gaps_pkg::DP_NOP;
            res_status <= gaps_pkg::ST_BAD_END;
          end else begin
            state  <= S_CLR;
            cur_op <= gaps_pkg::DP_SWEEP_NODE;
          end
        end
        S_CLR: begin
          if (sts.sweep_last) begin
            state  <= S_INIT;
            cur_op <= gaps_pkg::DP_INIT;
          end
        end
        S_INIT: begin
          state  <= S_LOOP;
          cur_op <= gaps_pkg::DP_NOP;
        end
        S_LOOP: begin
          if (sts.goal_open) begin
            state  <= S_TR_RD;
            cur_op <= gaps_pkg::DP_TR_READ;
          end else begin
            state  <= S_SCAN0;
            cur_op <= gaps_pkg::DP_SCAN_START;
          end
        end
        S_SCAN0: begin
          state  <= S_SCAN;
          cur_op <= gaps_pkg::DP_SCAN_STEP;
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state  <= S_DRAIN;
            cur_op <= gaps_pkg::DP_NOP;
          end
        end
        S_DRAIN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (sts.found) begin
            state  <= S_CLOSE;
            cur_op <= gaps_pkg::DP_CLOSE;
          end else begin
            state      <= S_RES;
            res_status <= gaps_pkg::ST_NO_PATH;
          end
        end
        S_CLOSE: begin
          state  <= S_NB_RD;
          cur_op <= gaps_pkg::DP_NB_READ;
        end
        S_NB_RD: begin
          state  <= S_NB_EV;
          cur_op <= gaps_pkg::DP_NB_EVAL;
        end
        S_NB_EV: begin
          if (sts.nb_last) begin
            state  <= S_LOOP;
            cur_op <= gaps_pkg::DP_NOP;
          end else begin
            state  <= S_NB_RD;
            cur_op <= gaps_pkg::DP_NB_READ;
          end
        end
        S_TR_RD: begin
          state  <= S_TR_ST;
          cur_op <= gaps_pkg::DP_TR_STEP;
        end
        S_TR_ST: begin
          if (sts.tr_done) begin
            state      <= S_RES;
            cur_op     <= gaps_pkg::DP_NOP;
            res_status <= gaps_pkg::ST_OK;
          end else begin
            state  <= S_TR_RD;
            cur_op <= gaps_pkg::DP_TR_READ;
          end
        end
        S_RES: begin
          if (out_free) begin
            state <= S_IDLE;
            stall <= 1'b0;
          end
        end
        S_PR_RD: begin
          state  <= S_PR_RES;
          cur_op <= gaps_pkg::DP_NOP;
        end
        S_PR_RES: begin
          if (out_free) begin
            state <= S_IDLE;
            stall <= 1'b0;
          end
        end
        default: begin
          state  <= S_IDLE;
          cur_op <= gaps_pkg::DP_NOP;
          stall  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ sv/grid_astar_path_search_core.sv @@
// top level of the 8-connected grid a-star path search core
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | op, cell_x, cell_y, blocked, path_index
//  out      | out_valid / out_stall| status, path_cost, path_length, out_x, out_y
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time; a cell write passes through S_OBS_WR, a path read through
// S_PR_RD and S_PR_RES plus any wait for the output register to free up
// a search reads start and goal, checks them, clears the node store and inits the
// start, then per expanded cell runs loop, scan start, a scan over the w*h cells,
// drain, pick, close and a read and an evaluation for each of the eight neighbors,
// then a trace read and step per path cell; the single-port node store, read once per cycle, paces these steps
// after reset a clearing pass over every cell address wipes the obstacle map and
// the node store; in_stall stays high meanwhile, cfg writes still land
// the output register holds a result under out_stall while the core moves on
module grid_astar_path_search_core #(
  parameter int MAX_SIDE  = 64,
  parameter int COST_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        blocked,
  input  logic [11:0] path_index,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] path_cost,
  output logic [12:0] path_length,
  output logic [5:0]  out_x,
  output logic [5:0]  out_y,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  gaps_pkg::cmd_t    cmd;
  gaps_pkg::dp_sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  gaps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gaps_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .blocked     (blocked),
    .path_index  (path_index),
    .status      (status),
    .path_cost   (path_cost),
    .path_length (path_length),
    .out_x       (out_x),
    .out_y       (out_y)
  );

endmodule

@@ sv/gaps_check.sv @@
// port-level checks for the grid path search core, bound to the top level
module gaps_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] path_cost,
  input logic [12:0] path_length,
  input logic [5:0]  out_x,
  input logic [5:0]  out_y
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset starts the clearing pass with input held off
  a_rst_stall: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open right after reset");

  // a search item blocks further input
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == gaps_pkg::OP_SEARCH |=> in_stall)
    else $error("input open during search");

  // failed results carry no cell
  a_fail_cell: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != gaps_pkg::ST_OK |-> out_x == 6'd0 && out_y == 6'd0)
    else $error("cell reported with failing status");

  // failed searches report no cost or length
  a_fail_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == gaps_pkg::ST_NO_PATH || status == gaps_pkg::ST_BAD_END)
    |-> path_cost == 16'd0 && path_length == 13'd0)
    else $error("cost reported for failed search");

endmodule

bind grid_astar_path_search_core gaps_check u_gaps_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .op          (op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .path_cost   (path_cost),
  .path_length (path_length),
  .out_x       (out_x),
  .out_y       (out_y)
);
